// ===== src/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray/sphere intersection unit
// Field widths, pipeline depth and the records passed between stages.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CoordW     = 24;
  localparam int VecW       = CoordW + 1;
  localparam int ProdW      = 2 * VecW;
  localparam int SumW       = ProdW + 2;
  localparam int R2W        = 48;
  localparam int BW         = 32;
  localparam int BMagW      = BW - 1;
  localparam int SqW        = 2 * BMagW;
  localparam int DiscW      = 64;
  localparam int DistW      = 32;
  localparam int RootW      = DiscW / 2;
  localparam int TW         = SumW + 2;
  localparam int SqrtStages = DiscW / 2;
  localparam int GeomStages = 6;
  localparam int Latency    = GeomStages + SqrtStages + 1;

  localparam logic signed [DiscW-1:0] DiscMax = {1'b0, {(DiscW-1){1'b1}}};
  localparam logic signed [TW-1:0]    DistMax = TW'({1'b0, {(DistW-1){1'b1}}});
  localparam logic signed [TW-1:0]    DistMin = -(TW'(1) <<< (DistW - 1));

  typedef struct packed {
    logic                    valid;
    logic                    hit;
    logic signed [SumW-1:0]  b;
    logic signed [DiscW-1:0] d;
  } rsi_disc_t;

  typedef struct packed {
    logic                    valid;
    logic                    hit;
    logic signed [SumW-1:0]  b;
    logic signed [DiscW-1:0] d;
    logic [RootW-1:0]        root;
  } rsi_root_t;

endpackage

// ===== src/rsi_geom.sv =====
// ----------------------------------------------------------------------------
// rsi_geom: offset, projection and discriminant pipeline
// Six register stages: offset, products, sums, rounding, square, discriminant.
// ----------------------------------------------------------------------------
module rsi_geom import rsi_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] origin_x_i,
  input  logic signed [CoordW-1:0] origin_y_i,
  input  logic signed [CoordW-1:0] origin_z_i,
  input  logic signed [CoordW-1:0] dir_x_i,
  input  logic signed [CoordW-1:0] dir_y_i,
  input  logic signed [CoordW-1:0] dir_z_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic        [R2W-1:0]    radius_sq_i,
  output rsi_disc_t                disc_o
);

  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SumW-1:0] BLim = SumW'(1) <<< (BW - 1);

  logic [GeomStages-2:0] vld_q;

  logic signed [VecW-1:0]   v1_q [3];
  logic signed [CoordW-1:0] u1_q [3];
  logic [R2W-1:0]           r2_1_q;

  logic signed [ProdW-1:0]  puv2_q [3];
  logic signed [ProdW-1:0]  pvv2_q [3];
  logic [R2W-1:0]           r2_2_q;

  logic signed [SumW-1:0]   bw3_q;
  logic signed [SumW-1:0]   l3_q;
  logic [R2W-1:0]           r2_3_q;

  logic signed [SumW-1:0]   b_full;
  logic                     sat_d;
  logic signed [BW-1:0]     b_abs;
  logic signed [SumW-1:0]   b4_q;
  logic [BMagW-1:0]         bmag4_q;
  logic                     sat4_q;
  logic signed [SumW-1:0]   l4_q;
  logic [R2W-1:0]           r2_4_q;

  logic [SqW-1:0]           bb5_q;
  logic signed [SumW-1:0]   b5_q;
  logic                     sat5_q;
  logic signed [SumW-1:0]   l5_q;
  logic [R2W-1:0]           r2_5_q;

  logic signed [DiscW-1:0]  disc_d;
  rsi_disc_t                disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[GeomStages-3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q[0] <= VecW'(origin_x_i) - VecW'(center_x_i);
    v1_q[1] <= VecW'(origin_y_i) - VecW'(center_y_i);
    v1_q[2] <= VecW'(origin_z_i) - VecW'(center_z_i);
    u1_q[0] <= dir_x_i;
    u1_q[1] <= dir_y_i;
    u1_q[2] <= dir_z_i;
    r2_1_q  <= radius_sq_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      puv2_q[i] <= ProdW'(u1_q[i]) * ProdW'(v1_q[i]);
      pvv2_q[i] <= ProdW'(v1_q[i]) * ProdW'(v1_q[i]);
    end
    r2_2_q <= r2_1_q;
  end

  always_ff @(posedge clk_i) begin
    bw3_q  <= SumW'(puv2_q[0]) + SumW'(puv2_q[1]) + SumW'(puv2_q[2]);
    l3_q   <= SumW'(pvv2_q[0]) + SumW'(pvv2_q[1]) + SumW'(pvv2_q[2]);
    r2_3_q <= r2_2_q;
  end

  always_comb begin
    b_full = (bw3_q + Half) >>> FRAC_BITS;
    sat_d  = (b_full >= BLim) || (b_full <= -BLim);
    b_abs  = b_full[BW-1] ? -b_full[BW-1:0] : b_full[BW-1:0];
  end

  always_ff @(posedge clk_i) begin
    b4_q    <= b_full;
    bmag4_q <= b_abs[BMagW-1:0];
    sat4_q  <= sat_d;
    l4_q    <= l3_q;
    r2_4_q  <= r2_3_q;
  end

  always_ff @(posedge clk_i) begin
    bb5_q  <= SqW'(bmag4_q) * SqW'(bmag4_q);
    b5_q   <= b4_q;
    sat5_q <= sat4_q;
    l5_q   <= l4_q;
    r2_5_q <= r2_4_q;
  end

  always_comb begin
    if (sat5_q) begin
      disc_d = DiscMax;
    end else begin
      disc_d = $signed(DiscW'(bb5_q)) - DiscW'(l5_q) + $signed(DiscW'(r2_5_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q <= '0;
    end else begin
      disc_q.valid <= vld_q[GeomStages-2];
      disc_q.hit   <= (disc_d > 0);
      disc_q.b     <= b5_q;
      disc_q.d     <= disc_d;
    end
  end

  assign disc_o = disc_q;

endmodule

// ===== src/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence over the discriminant.
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rsi_disc_t disc_i,
  output rsi_root_t root_o
);

  rsi_disc_t        meta [SqrtStages+1];
  logic [DiscW-1:0] x    [SqrtStages+1];
  logic [DiscW-1:0] r    [SqrtStages+1];

  assign meta[0] = disc_i;
  assign x[0]    = disc_i.d;
  assign r[0]    = '0;

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    localparam logic [DiscW-1:0] Bit = DiscW'(1) << (2 * (SqrtStages - 1 - k));

    logic [DiscW:0]   trial;
    logic             ge;
    logic [DiscW-1:0] x_d;
    logic [DiscW-1:0] r_d;
    rsi_disc_t        meta_q;
    logic [DiscW-1:0] x_q;
    logic [DiscW-1:0] r_q;

    always_comb begin
      trial = {1'b0, r[k]} + {1'b0, Bit};
      ge    = ({1'b0, x[k]} >= trial);
      x_d   = ge ? (x[k] - trial[DiscW-1:0]) : x[k];
      r_d   = ge ? ((r[k] >> 1) + Bit) : (r[k] >> 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q <= '0;
      end else begin
        meta_q <= meta[k];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q <= x_d;
      r_q <= r_d;
    end

    assign meta[k+1] = meta_q;
    assign x[k+1]    = x_q;
    assign r[k+1]    = r_q;
  end

  always_comb begin
    root_o.valid = meta[SqrtStages].valid;
    root_o.hit   = meta[SqrtStages].hit;
    root_o.b     = meta[SqrtStages].b;
    root_o.d     = meta[SqrtStages].d;
    root_o.root  = r[SqrtStages][RootW-1:0] ^ RootW'(x[SqrtStages] & '0);
  end

endmodule

// ===== src/rsi_root.sv =====
// ----------------------------------------------------------------------------
// rsi_root: nearer root and result register
// Forms -b - sqrt(D), clamps it to 32 bits (zero on a miss) and registers the result.
// ----------------------------------------------------------------------------
module rsi_root import rsi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsi_root_t               root_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic signed [DistW-1:0] distance_o,
  output logic signed [DiscW-1:0] discriminant_o
);

  logic signed [TW-1:0]    t;
  logic signed [DistW-1:0] dist_d;
  logic                    done_q;
  logic                    hit_q;
  logic signed [DistW-1:0] dist_q;
  logic signed [DiscW-1:0] disc_q;

  always_comb begin
    t = -TW'(root_i.b) - $signed(TW'(root_i.root));
    priority if (!root_i.hit) begin
      dist_d = '0;
    end else if (t > DistMax) begin
      dist_d = DistMax[DistW-1:0];
    end else if (t < DistMin) begin
      dist_d = DistMin[DistW-1:0];
    end else begin
      dist_d = t[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= root_i.hit;
    dist_q <= dist_d;
    disc_q <= root_i.d;
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign distance_o     = dist_q;
  assign discriminant_o = disc_q;

endmodule

// ===== src/ray_sphere_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersection_unit: nearer ray/sphere intersection, fixed point
// Streams one ray test per cycle through a 39-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the ray and sphere fields and raise start_i; the item
//   transfers at the rising edge where start_i is high and busy_o is low.
//   busy_o stays low, so a new ray transfers on every cycle.
//   Output: done_o is high for one cycle with hit_o, distance_o and
//   discriminant_o; the result transfers at the edge that ends that cycle.
//   Pipeline: six stages form the offset, products, sums, rounding,
//   square of b and the discriminant; 32 stages resolve the square root
//   one bit each; one stage forms and clamps the root and registers the
//   result.
//   Throughput: one ray per cycle, one result per ray, in order.
//   Reset: rst_ni clears every stage's valid bit; items in flight are
//   dropped and no result is shown for them.
//   The receiver has no back pressure; results must be taken as shown.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_unit import rsi_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [CoordW-1:0] origin_x_i,
  input  logic signed [CoordW-1:0] origin_y_i,
  input  logic signed [CoordW-1:0] origin_z_i,
  input  logic signed [CoordW-1:0] dir_x_i,
  input  logic signed [CoordW-1:0] dir_y_i,
  input  logic signed [CoordW-1:0] dir_z_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic        [R2W-1:0]    radius_sq_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [DistW-1:0]  distance_o,
  output logic signed [DiscW-1:0]  discriminant_o
);

  rsi_disc_t disc;
  rsi_root_t root;

  assign busy_o = 1'b0;

  rsi_geom #(
    .FRAC_BITS (FRAC_BITS)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .radius_sq_i (radius_sq_i),
    .disc_o      (disc)
  );

  rsi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .disc_i (disc),
    .root_o (root)
  );

  rsi_root u_root (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .root_i         (root),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .distance_o     (distance_o),
    .discriminant_o (discriminant_o)
  );

endmodule

// ===== src/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks of the intersection unit
// Fixed latency and consistency of hit, distance and discriminant.
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic                     hit_o,
  input logic signed [DistW-1:0]  distance_o,
  input logic signed [DiscW-1:0]  discriminant_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result missing after start transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without matching start transfer");

  a_hit_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (!discriminant_o[DiscW-1] && (discriminant_o != '0))))
    else $error("hit does not match discriminant sign");

  a_miss_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (distance_o == '0))
    else $error("nonzero distance on a miss");

endmodule

bind ray_sphere_intersection_unit rsi_checker u_rsi_checker (.*);
